FILE: hw/rtl/cot_tri_pkg.sv
package cot_tri_pkg;

   // result word and quotient search
   localparam int COT_WIDTH = 32;
   localparam int QUOT_BITS = 32;
   localparam logic [COT_WIDTH-1:0] COT_MAX_POS = 32'h7FFF_FFFF;
   localparam logic [COT_WIDTH-1:0] COT_MIN_MAG = 32'h8000_0000;

   // front stages: difference, products, sums, magnitudes, partials, squares, totals
   localparam int FRONT_STAGES = 7;

endpackage

FILE: hw/rtl/cotangent_of_triangle_angle.sv
// Cotangent of the apex angle of a 3D triangle (A, apex, B), as signed fixed point with
// RESULT_FRAC_BITS fraction bits in a 32-bit word, truncated toward zero and saturated.
// A collinear or coincident triangle returns 0 with degenerate set. The block takes one
// transaction per cycle unless req_stall is high, and each result passes through seven
// arithmetic stages that form the edge vectors, cross and dot products and their squares,
// then a chain of 32 compare-subtract stages that finds the quotient one bit per stage,
// and the output register. A stall on the result side fills empty stages before it holds
// the input.
module cotangent_of_triangle_angle
   import cot_tri_pkg::*;
#(
   parameter int COORD_WIDTH      = 24,
   parameter int RESULT_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_apex_x,
   input  logic signed [COORD_WIDTH-1:0] req_apex_y,
   input  logic signed [COORD_WIDTH-1:0] req_apex_z,
   input  logic signed [COORD_WIDTH-1:0] req_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COT_WIDTH-1:0]   rsp_cot_value,
   output logic                          rsp_degenerate,
   output logic                          rsp_saturated
);

   localparam int UW = COORD_WIDTH + 1;      // edge vector component
   localparam int PW = 2 * UW;               // component product
   localparam int MW = PW + 2;               // cross / dot and their magnitudes
   localparam int HL = (MW + 1) / 2;         // low half of a magnitude
   localparam int HH = MW - HL;              // high half
   localparam int QW = 2 * MW;               // square
   localparam int SW = QW + 2;               // sum of three squares
   localparam int XW = SW + 2 * QUOT_BITS + 2;  // remainder and running product
   localparam int NSTAGE = FRONT_STAGES + QUOT_BITS + 1;
   localparam int LAST = NSTAGE - 1;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] adv;

   always_comb begin
      adv[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTAGE; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // stage 0: edge vectors from the apex
   logic signed [COORD_WIDTH-1:0] pa [3];
   logic signed [COORD_WIDTH-1:0] pc [3];
   logic signed [COORD_WIDTH-1:0] pb [3];
   logic signed [UW-1:0] u_in [3];
   logic signed [UW-1:0] v_in [3];
   logic signed [UW-1:0] u_ff [3];
   logic signed [UW-1:0] v_ff [3];

   assign pa[0] = req_a_x;
   assign pa[1] = req_a_y;
   assign pa[2] = req_a_z;
   assign pc[0] = req_apex_x;
   assign pc[1] = req_apex_y;
   assign pc[2] = req_apex_z;
   assign pb[0] = req_b_x;
   assign pb[1] = req_b_y;
   assign pb[2] = req_b_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = $signed({pa[i][COORD_WIDTH-1], pa[i]}) - $signed({pc[i][COORD_WIDTH-1], pc[i]});
         v_in[i] = $signed({pb[i][COORD_WIDTH-1], pb[i]}) - $signed({pc[i][COORD_WIDTH-1], pc[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         u_ff <= u_in;
         v_ff <= v_in;
      end
   end

   // stage 1: the nine component products
   logic signed [PW-1:0] prod_in [9];
   logic signed [PW-1:0] prod_ff [9];

   always_comb begin
      prod_in[0] = PW'(u_ff[1]) * PW'(v_ff[2]);
      prod_in[1] = PW'(u_ff[2]) * PW'(v_ff[1]);
      prod_in[2] = PW'(u_ff[2]) * PW'(v_ff[0]);
      prod_in[3] = PW'(u_ff[0]) * PW'(v_ff[2]);
      prod_in[4] = PW'(u_ff[0]) * PW'(v_ff[1]);
      prod_in[5] = PW'(u_ff[1]) * PW'(v_ff[0]);
      prod_in[6] = PW'(u_ff[0]) * PW'(v_ff[0]);
      prod_in[7] = PW'(u_ff[1]) * PW'(v_ff[1]);
      prod_in[8] = PW'(u_ff[2]) * PW'(v_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         prod_ff <= prod_in;
      end
   end

   // stage 2: cross components and dot product, dot in slot 3
   logic signed [MW-1:0] sum_in [4];
   logic signed [MW-1:0] sum_ff [4];

   always_comb begin
      sum_in[0] = MW'(prod_ff[0]) - MW'(prod_ff[1]);
      sum_in[1] = MW'(prod_ff[2]) - MW'(prod_ff[3]);
      sum_in[2] = MW'(prod_ff[4]) - MW'(prod_ff[5]);
      sum_in[3] = MW'(prod_ff[6]) + MW'(prod_ff[7]) + MW'(prod_ff[8]);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sum_ff <= sum_in;
      end
   end

   // stage 3: magnitudes
   logic [MW-1:0] mag_in [4];
   logic [MW-1:0] mag_ff [4];
   logic          neg3_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag_in[i] = sum_ff[i][MW-1] ? MW'(-sum_ff[i]) : MW'(sum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         mag_ff  <= mag_in;
         neg3_ff <= sum_ff[3][MW-1];
      end
   end

   // stage 4: half-width partial products of each square
   logic [2*HH-1:0]    hh_in [4];
   logic [HH+HL-1:0]   hl_in [4];
   logic [2*HL-1:0]    ll_in [4];
   logic [2*HH-1:0]    hh_ff [4];
   logic [HH+HL-1:0]   hl_ff [4];
   logic [2*HL-1:0]    ll_ff [4];
   logic               neg4_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hh_in[i] = (2*HH)'(mag_ff[i][MW-1:HL]) * (2*HH)'(mag_ff[i][MW-1:HL]);
         hl_in[i] = (HH+HL)'(mag_ff[i][MW-1:HL]) * (HH+HL)'(mag_ff[i][HL-1:0]);
         ll_in[i] = (2*HL)'(mag_ff[i][HL-1:0]) * (2*HL)'(mag_ff[i][HL-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         neg4_ff <= neg3_ff;
      end
   end

   // stage 5: squares
   logic [QW-1:0] sq_in [4];
   logic [QW-1:0] sq_ff [4];
   logic          neg5_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq_in[i] = (QW'(hh_ff[i]) << (2*HL)) + (QW'(hl_ff[i]) << (HL+1)) + QW'(ll_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         sq_ff   <= sq_in;
         neg5_ff <= neg4_ff;
      end
   end

   // stage 6: squared cross length and scaled squared dot
   logic [SW-1:0] s6_ff;
   logic [XW-1:0] r6_ff;
   logic          neg6_ff;
   logic          degen6_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_ff     <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
         r6_ff     <= XW'(sq_ff[3]) << (2*RESULT_FRAC_BITS);
         neg6_ff   <= neg5_ff;
         degen6_ff <= (sq_ff[0] | sq_ff[1] | sq_ff[2]) == '0;
      end
   end

   // quotient search: largest q with q*q*s <= r, one bit per stage
   // rem holds r - q*q*s, pacc holds q*s
   logic [XW-1:0]        rem_ff   [QUOT_BITS];
   logic [XW-1:0]        pacc_ff  [QUOT_BITS];
   logic [SW-1:0]        it_s_ff  [QUOT_BITS];
   logic [QUOT_BITS-1:0] it_q_ff  [QUOT_BITS];
   logic                 it_neg_ff   [QUOT_BITS];
   logic                 it_degen_ff [QUOT_BITS];

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_iter
      localparam int BIT = QUOT_BITS - 1 - k;
      localparam int STG = FRONT_STAGES + k;

      logic [XW-1:0]        rem_src;
      logic [XW-1:0]        pacc_src;
      logic [SW-1:0]        s_src;
      logic [QUOT_BITS-1:0] q_src;
      logic                 neg_src;
      logic                 degen_src;
      logic [XW-1:0]        delta;
      logic                 take;

      if (k == 0) begin : g_first
         assign rem_src   = r6_ff;
         assign pacc_src  = '0;
         assign s_src     = s6_ff;
         assign q_src     = '0;
         assign neg_src   = neg6_ff;
         assign degen_src = degen6_ff;
      end else begin : g_next
         assign rem_src   = rem_ff[k-1];
         assign pacc_src  = pacc_ff[k-1];
         assign s_src     = it_s_ff[k-1];
         assign q_src     = it_q_ff[k-1];
         assign neg_src   = it_neg_ff[k-1];
         assign degen_src = it_degen_ff[k-1];
      end

      // (q + 2^b)^2 s - q^2 s = q*s*2^(b+1) + s*2^(2b)
      assign delta = (pacc_src << (BIT+1)) + (XW'(s_src) << (2*BIT));
      assign take  = delta <= rem_src;

      always_ff @(posedge clock) begin
         if (adv[STG]) begin
            rem_ff[k]      <= take ? rem_src - delta : rem_src;
            pacc_ff[k]     <= take ? pacc_src + (XW'(s_src) << BIT) : pacc_src;
            it_s_ff[k]     <= s_src;
            it_q_ff[k]     <= take ? (q_src | (QUOT_BITS'(1) << BIT)) : q_src;
            it_neg_ff[k]   <= neg_src;
            it_degen_ff[k] <= degen_src;
         end
      end
   end

   // output: sign, saturation, degenerate override
   logic [COT_WIDTH-1:0] qf;
   logic [COT_WIDTH-1:0] cot_in;
   logic                 sat_in;
   logic                 cot_sat;
   logic                 degen_out;

   assign qf = COT_WIDTH'(it_q_ff[QUOT_BITS-1]);

   always_comb begin
      cot_in  = '0;
      sat_in  = 1'b0;
      cot_sat = 1'b0;
      if (it_degen_ff[QUOT_BITS-1]) begin
         cot_in = '0;
         sat_in = 1'b0;
      end else if (it_neg_ff[QUOT_BITS-1]) begin
         cot_sat = qf > COT_MIN_MAG;
         sat_in  = cot_sat;
         cot_in  = cot_sat ? COT_MIN_MAG : COT_WIDTH'(-qf);
      end else begin
         cot_sat = qf > COT_MAX_POS;
         sat_in  = cot_sat;
         cot_in  = cot_sat ? COT_MAX_POS : qf;
      end
   end

   assign degen_out = it_degen_ff[QUOT_BITS-1];

   always_ff @(posedge clock) begin
      if (adv[LAST]) begin
         rsp_cot_value  <= $signed(cot_in);
         rsp_degenerate <= degen_out;
         rsp_saturated  <= sat_in;
      end
   end

endmodule

FILE: bench/tb_cotangent_of_triangle_angle.sv
`timescale 1ns / 1ps

module tb_cotangent_of_triangle_angle;
   import cot_tri_pkg::*;

   localparam int CW          = 24;
   localparam int FRAC        = 16;
   localparam int WDOG_LIMIT  = 3000;
   localparam int LONG_HOLD   = 400;

   typedef struct {
      logic signed [CW-1:0] c [9];   // a xyz, apex xyz, b xyz
      bit                   wait_empty;
   } corner_type;

   typedef struct packed {
      logic [COT_WIDTH-1:0] cot;
      logic                 degen;
      logic                 sat;
   } cot_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [COT_WIDTH-1:0] rsp_cot_value;
   logic rsp_degenerate, rsp_saturated;
   logic signed [CW-1:0] drv_pt [9];

   corner_type  pending_corners [$];
   cot_res_type expected_cots [$];
   int errors = 0, n_sent = 0, n_recv = 0, n_degen = 0, n_sat = 0;
   bit took = 1'b0;
   int idle_cycles = 0;

   initial for (int i = 0; i < 9; i++) drv_pt[i] = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   cotangent_of_triangle_angle i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_x(drv_pt[0]), .req_a_y(drv_pt[1]), .req_a_z(drv_pt[2]),
      .req_apex_x(drv_pt[3]), .req_apex_y(drv_pt[4]), .req_apex_z(drv_pt[5]),
      .req_b_x(drv_pt[6]), .req_b_y(drv_pt[7]), .req_b_z(drv_pt[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cot_value(rsp_cot_value), .rsp_degenerate(rsp_degenerate),
      .rsp_saturated(rsp_saturated)
   );

   // exact cotangent: largest q with q^2 |c|^2 <= d^2 2^(2 frac)
   function automatic cot_res_type predict_cot(logic signed [CW-1:0] p [9]);
      logic signed [63:0]  u [3];
      logic signed [63:0]  v [3];
      logic signed [127:0] cr [3];
      logic signed [127:0] dt;
      logic [255:0] s, rhs, lhs, m, dm;
      logic [63:0] q, cand;
      cot_res_type r;
      for (int i = 0; i < 3; i++) begin
         u[i] = p[i];
         u[i] = u[i] - p[3+i];
         v[i] = p[6+i];
         v[i] = v[i] - p[3+i];
      end
      cr[0] = u[1] * v[2] - u[2] * v[1];
      cr[1] = u[2] * v[0] - u[0] * v[2];
      cr[2] = u[0] * v[1] - u[1] * v[0];
      dt = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
      s = '0;
      for (int i = 0; i < 3; i++) begin
         m = {128'b0, (cr[i] < 0) ? -cr[i] : cr[i]};
         s = s + m * m;
      end
      r = '0;
      if (s == 0) begin
         r.degen = 1'b1;
         return r;
      end
      dm = {128'b0, (dt < 0) ? -dt : dt};
      rhs = (dm * dm) << (2 * FRAC);
      q = '0;
      for (int b = QUOT_BITS - 1; b >= 0; b--) begin
         cand = q | (64'd1 << b);
         lhs = {192'b0, cand};
         lhs = lhs * lhs * s;
         if (lhs <= rhs) q = cand;
      end
      if (dt < 0) begin
         if (q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            r.sat = 1'b1;
         end
         r.cot = -q[31:0];
      end else begin
         if (q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            r.sat = 1'b1;
         end
         r.cot = q[31:0];
      end
      return r;
   endfunction

   function automatic int short_gap();
      if ($urandom_range(0, 99) < 55) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // input side: predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_cots.push_back(predict_cot(drv_pt));
         n_sent++;
         took <= 1'b1;
      end else begin
         took <= 1'b0;
      end
   end

   // driver
   int gap_left = 0;
   always @(negedge clock) begin
      corner_type nxt;
      if (!reset && (!req_valid || took)) begin
         if (gap_left > 0 || pending_corners.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else if (pending_corners[0].wait_empty && expected_cots.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            nxt = pending_corners.pop_front();
            for (int i = 0; i < 9; i++) drv_pt[i] <= nxt.c[i];
            req_valid <= 1'b1;
            gap_left = short_gap();
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   int hold_left = 0;
   bit long_done = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!long_done && n_sent > 300) begin
            long_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if ((n_sent / 200) % 3 == 1) begin
            rsp_stall <= 1'b0;   // stretch with no stalls
         end else if ($urandom_range(0, 99) < 30) begin
            hold_left = short_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cot_res_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_recv++;
         if (rsp_degenerate) n_degen++;
         if (rsp_saturated) n_sat++;
         if (expected_cots.size() == 0) begin
            $error("unexpected transaction: cot_value %h", rsp_cot_value);
            errors++;
         end else begin
            e = expected_cots.pop_front();
            if (rsp_cot_value !== e.cot) begin
               $error("cot_value: expected %h actual %h", e.cot, rsp_cot_value);
               errors++;
            end
            if (rsp_degenerate !== e.degen) begin
               $error("degenerate: expected %b actual %b", e.degen, rsp_degenerate);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated: expected %b actual %b", e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: %0d sent, %0d received", n_sent, n_recv);
            $display("tb_cotangent_of_triangle_angle NOT OK");
            $finish;
         end
      end
   end

   task automatic add_corner(input int v [9], input bit wait_empty);
      corner_type t;
      for (int i = 0; i < 9; i++) t.c[i] = CW'(v[i]);
      t.wait_empty = wait_empty;
      pending_corners.push_back(t);
   endtask

   task automatic add_random_corner(input bit wait_empty);
      int v [9];
      int mode, k;
      mode = $urandom_range(0, 9);
      for (int i = 3; i < 6; i++) v[i] = $urandom;
      for (int i = 0; i < 3; i++) begin
         case (mode)
            0, 1, 2: begin
               v[i] = $urandom;
               v[6+i] = $urandom;
            end
            3, 4, 5: begin   // compact triangle near apex
               v[i] = v[3+i] + $signed($urandom_range(0, 256)) - 128;
               v[6+i] = v[3+i] + $signed($urandom_range(0, 256)) - 128;
            end
            6, 7: begin      // wider triangle
               v[i] = v[3+i] + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
               v[6+i] = v[3+i] + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            end
            default: begin   // collinear or nearly so, drives large or saturated values
               v[i] = v[3+i] + $signed($urandom_range(0, 2000)) - 1000;
            end
         endcase
      end
      if (mode >= 8) begin
         k = $signed($urandom_range(0, 8)) - 4;
         for (int i = 0; i < 3; i++)
            v[6+i] = v[3+i] + k * (v[i] - v[3+i]) + (mode == 9 ? $urandom_range(0, 1) : 0);
      end
      add_corner(v, wait_empty);
   endtask

   initial begin
      int mx, mn;
      mx = (1 << (CW - 1)) - 1;
      mn = -(1 << (CW - 1));
      // extremes of every field
      add_corner('{mx, mx, mx, mx, mx, mx, mx, mx, mx}, 1'b0);
      add_corner('{mn, mn, mn, mn, mn, mn, mn, mn, mn}, 1'b0);
      add_corner('{mx, mn, mx, mn, mx, mn, mx, mx, mn}, 1'b0);
      add_corner('{mn, mx, mn, mx, mn, mx, mn, mn, mx}, 1'b0);
      add_corner('{mx, 0, 0, mn, 0, 0, mn, mx, 0}, 1'b0);
      add_corner('{0, mx, mn, 0, mn, mx, mx, 0, mn}, 1'b0);
      // coincident points and collinear points
      add_corner('{5, 6, 7, 5, 6, 7, 5, 6, 7}, 1'b0);
      add_corner('{1, 2, 3, 0, 0, 0, 3, 6, 9}, 1'b0);
      add_corner('{1, 2, 3, 0, 0, 0, -2, -4, -6}, 1'b0);
      // right angle, 45 degrees, obtuse, cotangent 3
      add_corner('{4096, 0, 0, 0, 0, 0, 0, 4096, 0}, 1'b0);
      add_corner('{4096, 0, 0, 0, 0, 0, 4096, 4096, 0}, 1'b0);
      add_corner('{4096, 0, 0, 0, 0, 0, -4096, 4096, 0}, 1'b0);
      add_corner('{0, 0, 4096, 0, 0, 0, 4096, 0, 12288}, 1'b0);
      // result not exact in binary, truncation toward zero both signs
      add_corner('{3, 0, 0, 0, 0, 0, 1, 7, 0}, 1'b0);
      add_corner('{3, 0, 0, 0, 0, 0, -1, 7, 0}, 1'b0);
      // cot exactly -2^15 fits, +2^15 and beyond saturate
      add_corner('{1, 0, 0, 0, 0, 0, -32768, 1, 0}, 1'b0);
      add_corner('{1, 0, 0, 0, 0, 0, 32768, 1, 0}, 1'b0);
      add_corner('{1, 0, 0, 0, 0, 0, -32769, 1, 0}, 1'b0);
      add_corner('{1, 0, 0, 0, 0, 0, mn, 1, 0}, 1'b0);
      add_corner('{1, 0, 0, 0, 0, 0, mx, 1, 0}, 1'b0);
      // coordinate differences beyond the coordinate width, held in the wider edge components
      add_corner('{mx, 0, 0, mn, 0, 0, mn, 1, 0}, 1'b0);
      for (int n = 0; n < 1800; n++)
         add_random_corner(n == 900 || n == 1400);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_corners.size() == 0 && !req_valid && expected_cots.size() == 0);
      repeat (60) @(posedge clock);
      $display("covered %0d triangle corners: %0d degenerate, %0d saturated results",
               n_recv, n_degen, n_sat);
      $display("long result-side hold-off and a full drain pause were exercised");
      if (errors == 0 && expected_cots.size() == 0) begin
         $display("tb_cotangent_of_triangle_angle OK");
      end else begin
         $display("tb_cotangent_of_triangle_angle NOT OK");
      end
      $finish;
   end

endmodule
